// ===== hdl/raft_leader_election_node_core_defines.svh =====
// Assertion macros shared by the election node RTL.
// Macros expect signals clk and rst_n in the enclosing module.
`ifndef RAFT_LEADER_ELECTION_NODE_CORE_DEFINES_SVH
`define RAFT_LEADER_ELECTION_NODE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RLEN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RLEN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rlen_pkg.sv =====
// Shared types and codes for the election node.
// No dependencies.
`default_nettype none

package rlen_pkg;

    localparam int OP_BITS     = 3;
    localparam int KIND_BITS   = 3;
    localparam int ROLE_BITS   = 2;
    localparam int TMR_BITS    = 2;
    localparam int VOTE_BITS   = 8;
    localparam int CFG_BITS    = 8;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [OP_BITS-1:0] OP_VOTE_REQ   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND_REQ = 3'd1;
    localparam logic [OP_BITS-1:0] OP_SNAP_REQ   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_VOTE_RESP  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_ELECT_TO   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_HB_TO      = 3'd5;

    localparam logic [KIND_BITS-1:0] KIND_STATUS       = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_VOTE_REPLY   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_APPEND_REPLY = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_VOTE_BCAST   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_HB_BCAST     = 3'd4;

    localparam logic [ROLE_BITS-1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [ROLE_BITS-1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [ROLE_BITS-1:0] ROLE_LEADER    = 2'd2;

    localparam logic [TMR_BITS-1:0] TMR_NONE    = 2'd0;
    localparam logic [TMR_BITS-1:0] TMR_RESTART = 2'd1;
    localparam logic [TMR_BITS-1:0] TMR_STOP    = 2'd2;

    localparam logic [VOTE_BITS-1:0] VOTE_MAX = 8'hFF;

    localparam logic [CFG_IDX_BITS-1:0] CFG_OWN_ID   = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAJORITY = 1'd1;

    localparam logic [CFG_BITS-1:0] OWN_ID_RESET   = 8'd1;
    localparam logic [CFG_BITS-1:0] MAJORITY_RESET = 8'd2;

    // event class decided by the front end
    typedef struct packed {
        logic vote_req;
        logic append_req;
        logic snap_req;
        logic vote_gain;   // vote response that succeeded and granted
        logic elect_to;
        logic hb_to;
    } cls_t;

    localparam int CLS_BITS = $bits(cls_t);

    // fixed-width part of one result
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 flag;
        logic [ROLE_BITS-1:0] role;
        logic [TMR_BITS-1:0]  el_cmd;
        logic [TMR_BITS-1:0]  hb_cmd;
        logic                 last;
    } res_ctl_t;

    localparam int CTL_BITS = $bits(res_ctl_t);

endpackage

`default_nettype wire

// ===== hdl/rlen_fifo.sv =====
// Small register FIFO used for the event queue and the result queue.
// No package dependency.
`default_nettype none

module rlen_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rlen_front.sv =====
// Front end: decodes the event op into a class and packs the queue word.
// Depends on rlen_pkg.
`default_nettype none

module rlen_front #(
    parameter int TERM_BITS    = 32,
    parameter int NODE_ID_BITS = 8
) (
    input  wire logic [rlen_pkg::OP_BITS-1:0] op,
    input  wire logic [TERM_BITS-1:0]         msg_term_in,
    input  wire logic [NODE_ID_BITS-1:0]      sender_id,
    input  wire logic                         vote_granted_in,
    input  wire logic                         rpc_ok,
    output logic [rlen_pkg::CLS_BITS+TERM_BITS+NODE_ID_BITS-1:0] q_word
);

    rlen_pkg::cls_t cls;

    always_comb
    begin
        cls = '0;
        unique case (op)
            rlen_pkg::OP_VOTE_REQ:   cls.vote_req   = 1'b1;
            rlen_pkg::OP_APPEND_REQ: cls.append_req = 1'b1;
            rlen_pkg::OP_SNAP_REQ:   cls.snap_req   = 1'b1;
            // failed or refused responses change nothing
            rlen_pkg::OP_VOTE_RESP:  cls.vote_gain  = rpc_ok && vote_granted_in;
            rlen_pkg::OP_ELECT_TO:   cls.elect_to   = 1'b1;
            rlen_pkg::OP_HB_TO:      cls.hb_to      = 1'b1;
            default:                 cls = '0;
        endcase
    end

    assign q_word = {cls, msg_term_in, sender_id};

endmodule

`default_nettype wire

// ===== hdl/rlen_back.sv =====
// Back end: holds term/role/leader/vote state and executes queued events.
// Depends on rlen_pkg and the assertion macro header.
`default_nettype none
`include "raft_leader_election_node_core_defines.svh"

module rlen_back #(
    parameter int TERM_BITS    = 32,
    parameter int NODE_ID_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rlen_pkg::CFG_BITS-1:0] own_node_id,
    input  wire logic [rlen_pkg::CFG_BITS-1:0] vote_majority,
    input  wire logic                          q_empty,
    input  wire logic [rlen_pkg::CLS_BITS+TERM_BITS+NODE_ID_BITS-1:0] q_word,
    output logic                               q_pop,
    input  wire logic                          out_full,
    output logic                               out_push,
    output logic [rlen_pkg::CTL_BITS+TERM_BITS+2*NODE_ID_BITS-1:0] out_word
);

    localparam int NB = NODE_ID_BITS;

    rlen_pkg::cls_t         h_cls;
    logic [TERM_BITS-1:0]   h_term;
    logic [NB-1:0]          h_sender;

    logic [TERM_BITS-1:0]           term_reg, term_next;
    logic [rlen_pkg::ROLE_BITS-1:0] role_reg, role_next;
    logic [NB-1:0]                  leader_reg, leader_next;
    logic [NB-1:0]                  voted_reg, voted_next;
    logic [rlen_pkg::VOTE_BITS-1:0] votes_reg, votes_next;

    logic                 pend_reg;
    rlen_pkg::res_ctl_t   pend_ctl_reg;
    logic [TERM_BITS-1:0] pend_term_reg;
    logic [NB-1:0]        pend_node_reg;
    logic [NB-1:0]        pend_leader_reg;

    logic [NB+7:0] own_ext;
    logic [NB-1:0] own_id;

    logic term_lt, term_gt, tok, demote, is_req, two;
    logic [rlen_pkg::TMR_BITS-1:0]  el_cmd, hb_cmd;
    logic [rlen_pkg::KIND_BITS-1:0] kind0, kind1;
    logic                           flag0;

    rlen_pkg::res_ctl_t   ctl0, ctl1;
    logic [TERM_BITS-1:0] term0, term1;
    logic [NB-1:0]        node0, node1;
    logic                 exec;

    assign {h_cls, h_term, h_sender} = q_word;

    assign own_ext = {{NB{1'b0}}, own_node_id};
    assign own_id  = own_ext[NB-1:0];

    assign term_lt = (h_term < term_reg);
    assign term_gt = (h_term > term_reg);
    assign tok     = !term_lt;
    assign is_req  = h_cls.vote_req || h_cls.append_req || h_cls.snap_req;
    // newer term, or a candidate hearing from its own term
    assign demote  = is_req && tok && (term_gt || (role_reg == rlen_pkg::ROLE_CANDIDATE));

    always_comb
    begin
        term_next   = term_reg;
        role_next   = role_reg;
        leader_next = leader_reg;
        voted_next  = voted_reg;
        votes_next  = votes_reg;
        el_cmd      = rlen_pkg::TMR_NONE;
        hb_cmd      = rlen_pkg::TMR_NONE;
        kind0       = rlen_pkg::KIND_STATUS;
        kind1       = rlen_pkg::KIND_STATUS;
        flag0       = 1'b0;
        two         = 1'b0;

        if (demote)
        begin
            if (h_term != term_reg)
            begin
                voted_next = '0;
            end
            term_next   = h_term;
            leader_next = h_cls.vote_req ? '0 : h_sender;
            role_next   = rlen_pkg::ROLE_FOLLOWER;
            hb_cmd      = rlen_pkg::TMR_STOP;
            el_cmd      = rlen_pkg::TMR_RESTART;
        end

        if (h_cls.vote_req)
        begin
            kind0 = rlen_pkg::KIND_VOTE_REPLY;
            if (tok && (role_next == rlen_pkg::ROLE_FOLLOWER) &&
                ((voted_next == '0) || (voted_next == h_sender)))
            begin
                voted_next = h_sender;
                flag0      = 1'b1;
                el_cmd     = rlen_pkg::TMR_RESTART;
            end
        end
        else if (h_cls.append_req)
        begin
            kind0 = rlen_pkg::KIND_APPEND_REPLY;
            if (tok)
            begin
                flag0 = 1'b1;
                if (role_next == rlen_pkg::ROLE_FOLLOWER)
                begin
                    if (leader_next == '0)
                    begin
                        leader_next = h_sender;
                    end
                    el_cmd = rlen_pkg::TMR_RESTART;
                end
            end
        end
        else if (h_cls.vote_gain)
        begin
            if ((h_term == term_reg) && (role_reg == rlen_pkg::ROLE_CANDIDATE))
            begin
                if (votes_reg != rlen_pkg::VOTE_MAX)
                begin
                    votes_next = votes_reg + 1'b1;
                end
                if (votes_next >= vote_majority)
                begin
                    role_next   = rlen_pkg::ROLE_LEADER;
                    leader_next = own_id;
                    el_cmd      = rlen_pkg::TMR_STOP;
                    hb_cmd      = rlen_pkg::TMR_RESTART;
                    kind0       = rlen_pkg::KIND_HB_BCAST;
                end
            end
        end
        else if (h_cls.elect_to)
        begin
            role_next  = rlen_pkg::ROLE_CANDIDATE;
            hb_cmd     = rlen_pkg::TMR_STOP;
            el_cmd     = rlen_pkg::TMR_RESTART;
            if (term_reg != '1)
            begin
                term_next = term_reg + 1'b1;
            end
            voted_next = own_id;
            votes_next = rlen_pkg::VOTE_BITS'(1);
            kind0      = rlen_pkg::KIND_VOTE_BCAST;
            // self vote alone is a majority: win at once, heartbeat goes first
            if (vote_majority <= rlen_pkg::CFG_BITS'(1))
            begin
                role_next   = rlen_pkg::ROLE_LEADER;
                leader_next = own_id;
                el_cmd      = rlen_pkg::TMR_STOP;
                hb_cmd      = rlen_pkg::TMR_RESTART;
                kind0       = rlen_pkg::KIND_HB_BCAST;
                kind1       = rlen_pkg::KIND_VOTE_BCAST;
                two         = 1'b1;
            end
        end
        else if (h_cls.hb_to)
        begin
            if (role_reg == rlen_pkg::ROLE_LEADER)
            begin
                hb_cmd = rlen_pkg::TMR_RESTART;
                kind0  = rlen_pkg::KIND_HB_BCAST;
            end
        end
    end

    always_comb
    begin
        ctl0.kind   = kind0;
        ctl0.flag   = flag0;
        ctl0.role   = role_next;
        ctl0.el_cmd = el_cmd;
        ctl0.hb_cmd = hb_cmd;
        ctl0.last   = !two;
        ctl1        = ctl0;
        ctl1.kind   = kind1;
        ctl1.flag   = 1'b0;
        ctl1.last   = 1'b1;
        term0 = (kind0 == rlen_pkg::KIND_STATUS) ? '0 : term_next;
        term1 = (kind1 == rlen_pkg::KIND_STATUS) ? '0 : term_next;
        node0 = ((kind0 == rlen_pkg::KIND_VOTE_BCAST) || (kind0 == rlen_pkg::KIND_HB_BCAST)) ?
                own_id : '0;
        node1 = ((kind1 == rlen_pkg::KIND_VOTE_BCAST) || (kind1 == rlen_pkg::KIND_HB_BCAST)) ?
                own_id : '0;
    end

    // second result of an item is held in the pend registers and blocks the queue until pushed
    assign exec     = !pend_reg && !q_empty && !out_full;
    assign q_pop    = exec;
    assign out_push = exec || (pend_reg && !out_full);
    assign out_word = pend_reg ?
                      {pend_ctl_reg, pend_term_reg, pend_node_reg, pend_leader_reg} :
                      {ctl0, term0, node0, leader_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg   <= '0;
            role_reg   <= rlen_pkg::ROLE_FOLLOWER;
            leader_reg <= '0;
            voted_reg  <= '0;
            votes_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                term_reg   <= term_next;
                role_reg   <= role_next;
                leader_reg <= leader_next;
                voted_reg  <= voted_next;
                votes_reg  <= votes_next;
                pend_reg   <= two;
            end
            else if (pend_reg && !out_full)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            pend_ctl_reg    <= ctl1;
            pend_term_reg   <= term1;
            pend_node_reg   <= node1;
            pend_leader_reg <= leader_next;
        end
    end

    `RLEN_ASSERT_NOW(a_no_pop_while_pend, pend_reg, !q_pop, "event popped while a result is held")
    `RLEN_ASSERT_NEXT(a_two_sets_pend, exec && two, pend_reg, "second result not held")
    `RLEN_ASSERT_NEXT(a_pend_drains, pend_reg && !out_full, !pend_reg, "held result not drained")
    `RLEN_ASSERT_NOW(a_cand_has_vote, role_reg == rlen_pkg::ROLE_CANDIDATE, votes_reg != '0,
        "candidate without its own vote")

endmodule

`default_nettype wire

// ===== hdl/raft_leader_election_node_core.sv =====
// Raft election node: event queue -> executor -> result queue.
// Path: an accepted event is stored in the event queue, executed combinationally from its head and
// its first result registered in the result queue, from whose head it can be popped.
// Throughput: one event per cycle while the result queue is not full; an event with two results
// holds the executor until its second result is pushed.
// Reset (rst_n, async, active low): term 0, follower, no leader, no vote, queues empty,
// own id 1, majority 2.
`default_nettype none

module raft_leader_election_node_core #(
    parameter int TERM_BITS    = 32,
    parameter int NODE_ID_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rlen_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [rlen_pkg::CFG_BITS-1:0]     cfg_wdata,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [rlen_pkg::OP_BITS-1:0]      op,
    input  wire logic [TERM_BITS-1:0]              msg_term_in,
    input  wire logic [NODE_ID_BITS-1:0]           sender_id,
    input  wire logic                              vote_granted_in,
    input  wire logic                              rpc_ok,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [rlen_pkg::KIND_BITS-1:0]         msg_kind,
    output logic [TERM_BITS-1:0]                   msg_term_out,
    output logic                                   msg_flag,
    output logic [NODE_ID_BITS-1:0]                msg_node,
    output logic [rlen_pkg::ROLE_BITS-1:0]         role_now,
    output logic [NODE_ID_BITS-1:0]                leader_now,
    output logic [rlen_pkg::TMR_BITS-1:0]          election_timer_cmd,
    output logic [rlen_pkg::TMR_BITS-1:0]          heartbeat_timer_cmd,
    output logic                                   last_result
);

    localparam int QW = rlen_pkg::CLS_BITS + TERM_BITS + NODE_ID_BITS;
    localparam int RW = rlen_pkg::CTL_BITS + TERM_BITS + 2 * NODE_ID_BITS;
    localparam int QUEUE_DEPTH = 2;

    logic [rlen_pkg::CFG_BITS-1:0] own_id_reg;
    logic [rlen_pkg::CFG_BITS-1:0] majority_reg;

    logic [QW-1:0] in_word, q_word;
    logic          q_empty, q_pop;
    logic [RW-1:0] res_word, head_word;
    logic          out_full, out_push;

    rlen_pkg::res_ctl_t head_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= rlen_pkg::OWN_ID_RESET;
            majority_reg <= rlen_pkg::MAJORITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlen_pkg::CFG_OWN_ID:   own_id_reg   <= cfg_wdata;
                rlen_pkg::CFG_MAJORITY: majority_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rlen_front #(
        .TERM_BITS    (TERM_BITS),
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_front (
        .op              (op),
        .msg_term_in     (msg_term_in),
        .sender_id       (sender_id),
        .vote_granted_in (vote_granted_in),
        .rpc_ok          (rpc_ok),
        .q_word          (in_word)
    );

    rlen_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_evq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_word),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_word),
        .empty (q_empty)
    );

    rlen_back #(
        .TERM_BITS    (TERM_BITS),
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .own_node_id   (own_id_reg),
        .vote_majority (majority_reg),
        .q_empty       (q_empty),
        .q_word        (q_word),
        .q_pop         (q_pop),
        .out_full      (out_full),
        .out_push      (out_push),
        .out_word      (res_word)
    );

    rlen_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (res_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (head_word),
        .empty (empty)
    );

    assign {head_ctl, msg_term_out, msg_node, leader_now} = head_word;
    assign msg_kind            = head_ctl.kind;
    assign msg_flag            = head_ctl.flag;
    assign role_now            = head_ctl.role;
    assign election_timer_cmd  = head_ctl.el_cmd;
    assign heartbeat_timer_cmd = head_ctl.hb_cmd;
    assign last_result         = head_ctl.last;

endmodule

`default_nettype wire
